>>> design/alr_pkg.sv
// ----------------------------------------------------------------------------
// alr_pkg
// Shared types and constants of the anti-aliased line rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package alr_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS      = 16;
  localparam int PIX_BITS       = 12;
  localparam int RGB_BITS       = 24;
  localparam int ALPHA_BITS     = 8;
  localparam int CANVAS_BITS    = 13;
  localparam int CFG_IDX_BITS   = 2;
  localparam int OUT_DATA_W     = 2 * PIX_BITS + RGB_BITS + ALPHA_BITS;

  localparam logic [CANVAS_BITS-1:0]  CANVAS_W_RESET = 13'd256;
  localparam logic [CANVAS_BITS-1:0]  CANVAS_H_RESET = 13'd240;
  localparam logic [CANVAS_BITS-1:0]  CANVAS_MAX     = 13'd4096;
  localparam logic [CFG_IDX_BITS-1:0] REG_CANVAS_W   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CANVAS_H   = 2'd1;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_HORIZ,
    MODE_VERT,
    MODE_DIAG,
    MODE_XMAJ,
    MODE_YMAJ,
    MODE_END
  } mode_e;

  typedef enum logic [1:0] {
    EK_NONE,
    EK_ONE,
    EK_PAIR
  } emit_kind_e;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic load_p0;
    logic load_p1;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_need;
    logic p0_ok;
    logic p1_ok;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

>>> design/alr_datapath.sv
// ----------------------------------------------------------------------------
// alr_datapath
// Line state, slope divider, pixel weighting, canvas clip and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module alr_datapath #(
  parameter int COORD_BITS = alr_pkg::COORD_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire alr_pkg::ctrl_cmd_t                  cmd_i,
  output alr_pkg::dp_status_t                      status_o,
  input  wire logic                                action_i,
  input  wire logic signed [COORD_BITS-1:0]        x_start_i,
  input  wire logic signed [COORD_BITS-1:0]        y_start_i,
  input  wire logic signed [COORD_BITS-1:0]        x_end_i,
  input  wire logic signed [COORD_BITS-1:0]        y_end_i,
  input  wire logic [alr_pkg::RGB_BITS-1:0]        color_rgb_i,
  input  wire logic [alr_pkg::ALPHA_BITS-1:0]      alpha_in_i,
  input  wire logic                                cfg_we_i,
  input  wire logic [alr_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  wire logic [alr_pkg::CANVAS_BITS-1:0]     cfg_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [alr_pkg::PIX_BITS-1:0]             pixel_x_o,
  output logic [alr_pkg::PIX_BITS-1:0]             pixel_y_o,
  output logic [alr_pkg::RGB_BITS-1:0]             pixel_rgb_o,
  output logic [alr_pkg::ALPHA_BITS-1:0]           pixel_alpha_o,
  output logic                                     last_of_step_o,
  output logic                                     line_done_o
);
  import alr_pkg::*;

  localparam int CW = COORD_BITS + 2;
  localparam int DW = COORD_BITS + 1;
  localparam int SW = COORD_BITS + 1;

  function automatic logic on_canvas(input logic signed [CW-1:0] v,
                                     input logic [CANVAS_BITS-1:0] size);
    logic [CANVAS_BITS:0]        lim;
    logic signed [CW+CANVAS_BITS:0] ve;
    logic signed [CW+CANVAS_BITS:0] le;
    lim = (size > CANVAS_MAX) ? {1'b0, CANVAS_MAX} : {1'b0, size};
    ve  = {{(CANVAS_BITS+1){v[CW-1]}}, v};
    le  = $signed({{CW{1'b0}}, lim});
    on_canvas = !v[CW-1] && (ve < le);
  endfunction

  logic [CANVAS_BITS-1:0] canvas_w_q, canvas_h_q;
  logic signed [CW-1:0]   cur_x_q, cur_y_q, goal_x_q, goal_y_q;
  logic signed [CW-1:0]   cur_x_d, cur_y_d;
  logic                   x_neg_q;
  logic [SW-1:0]          steps_q, steps_d;
  logic [FRAC_BITS-1:0]   acc_q, acc_d, inc_q;
  mode_e                  mode_q, mode_d;
  logic [RGB_BITS-1:0]    rgb_q;
  logic [ALPHA_BITS-1:0]  alpha_q;
  emit_kind_e             kind_q, kind_d;
  logic                   pair_ymaj_q, pair_ymaj_d;
  logic                   done_q, done_d;
  logic [DW-1:0]          rem_q;
  logic [COORD_BITS-1:0]  major_q;

  // start decode
  logic                          swap;
  logic signed [COORD_BITS-1:0]  ax, ay, bx, by;
  logic signed [COORD_BITS:0]    dx_s, dy_s, dx_n;
  logic [COORD_BITS-1:0]         dx_abs, dy_abs;
  logic                          dx_zero, dy_zero, d_eq, y_major;

  always_comb begin
    swap    = y_start_i > y_end_i;
    ax      = swap ? x_end_i   : x_start_i;
    ay      = swap ? y_end_i   : y_start_i;
    bx      = swap ? x_start_i : x_end_i;
    by      = swap ? y_start_i : y_end_i;
    dx_s    = {bx[COORD_BITS-1], bx} - {ax[COORD_BITS-1], ax};
    dy_s    = {by[COORD_BITS-1], by} - {ay[COORD_BITS-1], ay};
    dx_n    = -dx_s;
    dx_abs  = dx_s[COORD_BITS] ? dx_n[COORD_BITS-1:0] : dx_s[COORD_BITS-1:0];
    dy_abs  = dy_s[COORD_BITS-1:0];
    dx_zero = dx_abs == '0;
    dy_zero = dy_abs == '0;
    d_eq    = dx_abs == dy_abs;
    y_major = dy_abs > dx_abs;
  end

  // step update
  logic signed [CW-1:0]  xinc, x_plus, y_plus;
  logic [FRAC_BITS:0]    acc_sum;
  logic [SW-1:0]         steps_dec;

  always_comb begin
    xinc      = x_neg_q ? {CW{1'b1}} : {{(CW-1){1'b0}}, 1'b1};
    x_plus    = cur_x_q + xinc;
    y_plus    = cur_y_q + {{(CW-1){1'b0}}, 1'b1};
    acc_sum   = {1'b0, acc_q} + {1'b0, inc_q};
    steps_dec = (steps_q != '0) ? steps_q - {{(SW-1){1'b0}}, 1'b1} : steps_q;

    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    steps_d     = steps_q;
    acc_d       = acc_q;
    mode_d      = mode_q;
    kind_d      = EK_NONE;
    pair_ymaj_d = pair_ymaj_q;
    done_d      = 1'b0;
    unique case (mode_q)
      MODE_HORIZ, MODE_VERT, MODE_DIAG: begin
        if (mode_q != MODE_VERT) cur_x_d = x_plus;
        if (mode_q != MODE_HORIZ) cur_y_d = y_plus;
        steps_d = steps_dec;
        done_d  = steps_dec == '0;
        if (steps_dec == '0) mode_d = MODE_IDLE;
        kind_d  = EK_ONE;
      end
      MODE_XMAJ, MODE_YMAJ: begin
        acc_d = acc_sum[FRAC_BITS-1:0];
        if (mode_q == MODE_YMAJ) begin
          cur_y_d = y_plus;
          if (acc_sum[FRAC_BITS]) cur_x_d = x_plus;
        end else begin
          cur_x_d = x_plus;
          if (acc_sum[FRAC_BITS]) cur_y_d = y_plus;
        end
        pair_ymaj_d = mode_q == MODE_YMAJ;
        steps_d     = steps_dec;
        if (steps_dec == '0) mode_d = MODE_END;
        kind_d      = EK_PAIR;
      end
      MODE_END: begin
        cur_x_d = goal_x_q;
        cur_y_d = goal_y_q;
        mode_d  = MODE_IDLE;
        done_d  = 1'b1;
        kind_d  = EK_ONE;
      end
      default: begin
        mode_d = MODE_IDLE;
      end
    endcase
  end

  // divider step
  logic [DW-1:0] rem_sh, rem_sub;
  logic          rem_ge;

  always_comb begin
    rem_sh  = {rem_q[DW-2:0], 1'b0};
    rem_ge  = rem_sh >= {1'b0, major_q};
    rem_sub = rem_sh - {1'b0, major_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canvas_w_q  <= CANVAS_W_RESET;
      canvas_h_q  <= CANVAS_H_RESET;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      goal_x_q    <= '0;
      goal_y_q    <= '0;
      x_neg_q     <= 1'b0;
      steps_q     <= '0;
      acc_q       <= '0;
      inc_q       <= '0;
      mode_q      <= MODE_IDLE;
      rgb_q       <= '0;
      alpha_q     <= '0;
      kind_q      <= EK_NONE;
      pair_ymaj_q <= 1'b0;
      done_q      <= 1'b0;
      rem_q       <= '0;
      major_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_CANVAS_W) canvas_w_q <= cfg_data_i;
        if (cfg_index_i == REG_CANVAS_H) canvas_h_q <= cfg_data_i;
      end
      if (cmd_i.div_step) begin
        rem_q <= rem_ge ? rem_sub : rem_sh;
        inc_q <= {inc_q[FRAC_BITS-2:0], rem_ge};
      end
      if (cmd_i.accept) begin
        if (!action_i) begin
          cur_x_q     <= CW'(ax);
          cur_y_q     <= CW'(ay);
          goal_x_q    <= CW'(bx);
          goal_y_q    <= CW'(by);
          x_neg_q     <= dx_s[COORD_BITS];
          rgb_q       <= color_rgb_i;
          alpha_q     <= alpha_in_i;
          acc_q       <= '0;
          inc_q       <= '0;
          kind_q      <= EK_ONE;
          done_q      <= dx_zero && dy_zero;
          major_q     <= y_major ? dy_abs : dx_abs;
          rem_q       <= {1'b0, (y_major ? dx_abs : dy_abs)};
          if (dy_zero) begin
            mode_q  <= dx_zero ? MODE_IDLE : MODE_HORIZ;
            steps_q <= {1'b0, dx_abs};
          end else if (dx_zero || d_eq) begin
            mode_q  <= dx_zero ? MODE_VERT : MODE_DIAG;
            steps_q <= {1'b0, dy_abs};
          end else if (y_major) begin
            mode_q  <= MODE_YMAJ;
            steps_q <= {1'b0, dy_abs} - {{(SW-1){1'b0}}, 1'b1};
          end else begin
            mode_q  <= MODE_XMAJ;
            steps_q <= {1'b0, dx_abs} - {{(SW-1){1'b0}}, 1'b1};
          end
        end else begin
          cur_x_q     <= cur_x_d;
          cur_y_q     <= cur_y_d;
          steps_q     <= steps_d;
          acc_q       <= acc_d;
          mode_q      <= mode_d;
          kind_q      <= kind_d;
          pair_ymaj_q <= pair_ymaj_d;
          done_q      <= done_d;
        end
      end
    end
  end

  // pixel candidates
  logic [ALPHA_BITS-1:0]   w, w_inv;
  logic [2*ALPHA_BITS-1:0] prod_pair, prod_main;
  logic signed [CW-1:0]    p0_x, p0_y;
  logic [ALPHA_BITS-1:0]   p1_alpha;
  logic signed [CW+PIX_BITS-1:0] p0_xe, p0_ye, p1_xe, p1_ye;

  always_comb begin
    w         = acc_q[FRAC_BITS-1 -: ALPHA_BITS];
    w_inv     = ~w;
    prod_pair = alpha_q * w;
    prod_main = alpha_q * w_inv;
    p0_x      = pair_ymaj_q ? x_plus : cur_x_q;
    p0_y      = pair_ymaj_q ? cur_y_q : y_plus;
    p1_alpha  = (kind_q == EK_PAIR) ? prod_main[2*ALPHA_BITS-1 -: ALPHA_BITS] : alpha_q;
    p0_xe     = {{PIX_BITS{p0_x[CW-1]}}, p0_x};
    p0_ye     = {{PIX_BITS{p0_y[CW-1]}}, p0_y};
    p1_xe     = {{PIX_BITS{cur_x_q[CW-1]}}, cur_x_q};
    p1_ye     = {{PIX_BITS{cur_y_q[CW-1]}}, cur_y_q};
    status_o.div_need = !action_i && !dx_zero && !dy_zero && !d_eq;
    status_o.p0_ok    = (kind_q == EK_PAIR) && on_canvas(p0_x, canvas_w_q)
                        && on_canvas(p0_y, canvas_h_q);
    status_o.p1_ok    = (kind_q != EK_NONE) && on_canvas(cur_x_q, canvas_w_q)
                        && on_canvas(cur_y_q, canvas_h_q);
    status_o.out_free = !out_valid_o || out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.load_p0 || cmd_i.load_p1) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_p0) begin
      pixel_x_o      <= p0_xe[PIX_BITS-1:0];
      pixel_y_o      <= p0_ye[PIX_BITS-1:0];
      pixel_rgb_o    <= rgb_q;
      pixel_alpha_o  <= prod_pair[2*ALPHA_BITS-1 -: ALPHA_BITS];
      last_of_step_o <= !status_o.p1_ok;
      line_done_o    <= 1'b0;
    end else if (cmd_i.load_p1) begin
      pixel_x_o      <= p1_xe[PIX_BITS-1:0];
      pixel_y_o      <= p1_ye[PIX_BITS-1:0];
      pixel_rgb_o    <= rgb_q;
      pixel_alpha_o  <= p1_alpha;
      last_of_step_o <= 1'b1;
      line_done_o    <= done_q;
    end
  end

endmodule

`default_nettype wire

>>> design/alr_ctrl.sv
// ----------------------------------------------------------------------------
// alr_ctrl
// Sequencer: accept, slope division, emission of the paired and main pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module alr_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire alr_pkg::dp_status_t status_i,
  output alr_pkg::ctrl_cmd_t       cmd_o
);
  import alr_pkg::*;

  localparam int CNT_W = $clog2(FRAC_BITS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_PIX0,
    S_PIX1
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;

  always_comb begin
    in_ready_o     = state_q == S_IDLE;
    cmd_o.accept   = in_ready_o && in_valid_i;
    cmd_o.div_step = state_q == S_DIV;
    cmd_o.load_p0  = (state_q == S_PIX0) && status_i.p0_ok && status_i.out_free;
    cmd_o.load_p1  = (state_q == S_PIX1) && status_i.p1_ok && status_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (cmd_o.accept) begin
            cnt_q   <= CNT_W'(FRAC_BITS - 1);
            state_q <= status_i.div_need ? S_DIV : S_PIX0;
          end
        end
        S_DIV: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) state_q <= S_PIX0;
        end
        S_PIX0: begin
          if (!status_i.p0_ok || status_i.out_free) state_q <= S_PIX1;
        end
        S_PIX1: begin
          if (!status_i.p1_ok || status_i.out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/antialiased_line_rasterizer_core.sv
// Emission: the paired pixel of a step is registered into the output from S_PIX0, the main or
// single pixel from S_PIX1; a sloped line start first runs the 16-bit bit-serial slope divider
// in S_DIV. A new input beat is taken only in S_IDLE, once the previous item is fully emitted.
// Output stalls hold the sequencer in its emit states until the beat is taken.
// Reset: asynchronous, active low; canvas returns to 256 x 240, no line active.
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer_core
// Wu-style anti-aliased line rasterizer with stream input and output.
// ----------------------------------------------------------------------------
`default_nettype none

module antialiased_line_rasterizer_core #(
  parameter int COORD_BITS = alr_pkg::COORD_BITS_DEF,
  parameter int IN_DATA_W  = ((4 * COORD_BITS + 32 + 7) / 8) * 8
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // x_start, y_start, x_end, y_end, color_rgb, alpha_in
  input  wire logic [IN_DATA_W-1:0]               s_axis_tdata,
  // action
  input  wire logic                               s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // pixel_x, pixel_y, pixel_rgb, pixel_alpha
  output logic [alr_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
  output logic                                    m_axis_tlast,
  // line_done
  output logic                                    m_axis_tuser,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [alr_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  wire logic [alr_pkg::CANVAS_BITS-1:0]    cfg_data_i
);
  import alr_pkg::*;

  localparam int C = COORD_BITS;

  ctrl_cmd_t             cmd;
  dp_status_t            status;
  logic [PIX_BITS-1:0]   px, py;
  logic [RGB_BITS-1:0]   prgb;
  logic [ALPHA_BITS-1:0] palpha;

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tdata = {palpha, prgb, py, px};

  alr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  alr_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .action_i       (s_axis_tuser),
    .x_start_i      ($signed(s_axis_tdata[C-1:0])),
    .y_start_i      ($signed(s_axis_tdata[2*C-1:C])),
    .x_end_i        ($signed(s_axis_tdata[3*C-1:2*C])),
    .y_end_i        ($signed(s_axis_tdata[4*C-1:3*C])),
    .color_rgb_i    (s_axis_tdata[4*C+RGB_BITS-1:4*C]),
    .alpha_in_i     (s_axis_tdata[4*C+RGB_BITS+ALPHA_BITS-1:4*C+RGB_BITS]),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .pixel_x_o      (px),
    .pixel_y_o      (py),
    .pixel_rgb_o    (prgb),
    .pixel_alpha_o  (palpha),
    .last_of_step_o (m_axis_tlast),
    .line_done_o    (m_axis_tuser)
  );

endmodule

`default_nettype wire

>>> design/alr_checker.sv
// ----------------------------------------------------------------------------
// alr_checker
// Port-level checks of the rasterizer core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module alr_checker #(
  parameter int OUT_W = alr_pkg::OUT_DATA_W
) (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             s_axis_tvalid,
  input wire logic             s_axis_tready,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [OUT_W-1:0] m_axis_tdata,
  input wire logic             m_axis_tlast,
  input wire logic             m_axis_tuser
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output payload changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("line end pixel not last of its step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while previous item still in work");

endmodule

bind antialiased_line_rasterizer_core alr_checker u_alr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
